// File: hdl/base64_bitmap_payload_decoder_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the base64 bitmap payload decoder checker
// Clocked on the decoder clock; reset is left to each caller's antecedent.
// ----------------------------------------------------------------------------
`ifndef BASE64_BITMAP_PAYLOAD_DECODER_TOP_MACROS_SVH
`define BASE64_BITMAP_PAYLOAD_DECODER_TOP_MACROS_SVH

// Same-cycle implication
`define B64D_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define B64D_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/b64d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, constants and the character table shared by the decoder modules.
// ----------------------------------------------------------------------------
package b64d_pkg;

   localparam int MAX_BYTES  = 4096;
   localparam int CFG_W      = 12;
   localparam int COUNT_W    = 13;
   localparam int PROD_W     = 22;

   // ASCII codes
   localparam logic [7:0] CHAR_TERM    = 8'h00;
   localparam logic [7:0] CHAR_PAD     = 8'h3D;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;

   localparam logic [7:0] LOWER_BASE = 8'd26;
   localparam logic [7:0] DIGIT_BASE = 8'd52;
   localparam logic [5:0] PLUS_CODE  = 6'd62;
   localparam logic [5:0] SLASH_CODE = 6'd63;

   typedef enum logic {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_GEOM  = 3'd1,
      ST_CHAR  = 3'd2,
      ST_LONG  = 3'd3,
      ST_SHORT = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      PH_COLLECT = 2'd0,
      PH_STOPPED = 2'd1,
      PH_ERROR   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      CMD_TERM = 2'd0,
      CMD_PAD  = 2'd1,
      CMD_DATA = 2'd2,
      CMD_BAD  = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [5:0]   sextet;
   } cmd_type;

   typedef struct packed {
      logic               ok;
      logic [COUNT_W-1:0] need;
   } geom_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       kind;
      status_type status;
      logic       last;
   } result_type;

   // Classify one character; sextet is only meaningful for CMD_DATA.
   function automatic cmd_type classify(logic [7:0] c);
      cmd_type r;
      r.kind   = CMD_BAD;
      r.sextet = '0;
      if (c == CHAR_TERM) begin
         r.kind = CMD_TERM;
      end else if (c == CHAR_PAD) begin
         r.kind = CMD_PAD;
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r.kind   = CMD_DATA;
         r.sextet = 6'(c - CHAR_UPPER_A);
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         r.kind   = CMD_DATA;
         r.sextet = 6'(c - CHAR_LOWER_A + LOWER_BASE);
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         r.kind   = CMD_DATA;
         r.sextet = 6'(c - CHAR_DIGIT_0 + DIGIT_BASE);
      end else if (c == CHAR_PLUS) begin
         r.kind   = CMD_DATA;
         r.sextet = PLUS_CODE;
      end else if (c == CHAR_SLASH) begin
         r.kind   = CMD_DATA;
         r.sextet = SLASH_CODE;
      end
      return r;
   endfunction

endpackage

// File: hdl/b64d_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_csr
// Geometry registers; the expected byte count is computed on each write.
// ----------------------------------------------------------------------------
module b64d_csr import b64d_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  csr_index_type    csr_index,
   input  logic [CFG_W-1:0] csr_wdata,
   output geom_type         geom
);

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   geom_type         geom_ff, geom_in;
   logic [9:0]       row_bytes;
   logic [PROD_W-1:0] product;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_WIDTH:  width_in  = csr_wdata;
            CSR_HEIGHT: height_in = csr_wdata;
            default:    width_in  = width_ff;
         endcase
      end
      // ceil(width/8) bytes per row
      row_bytes  = 10'((13'(width_in) + 13'd7) >> 3);
      product    = PROD_W'(row_bytes) * PROD_W'(height_in);
      geom_in.ok = (width_in != '0) && (height_in != '0)
                   && (product <= PROD_W'(MAX_BYTES));
      geom_in.need = geom_in.ok ? COUNT_W'(product) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
         geom_ff   <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         geom_ff   <= geom_in;
      end
   end

   assign geom = geom_ff;

endmodule

// File: hdl/b64d_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module b64d_front import b64d_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_char_code,
   output logic       cmd_valid,
   output cmd_type    cmd,
   input  logic       cmd_pop
);

   cmd_type    cmd_q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign req_full  = (count_ff == 2'd2);
   assign push      = req_push && !req_full;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = cmd_q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ cmd_pop;
      count_in  = count_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_q_ff[wr_ptr_ff] <= classify(req_char_code);
      end
   end

endmodule

// File: hdl/b64d_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_back
// Runs the decode state per command and queues bytes and status results.
// ----------------------------------------------------------------------------
module b64d_back import b64d_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_pop,
   input  geom_type    geom,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output result_type  rsp_item
);

   phase_type          phase_ff, phase_in;
   logic [11:0]        bit_store_ff, bit_store_in;
   logic [2:0]         bits_held_ff, bits_held_in;
   logic [COUNT_W-1:0] emitted_ff, emitted_in;
   status_type         error_ff, error_in;

   result_type res_q_ff [2];
   logic       res_wr_ff, res_rd_ff;
   logic [1:0] res_count_ff, res_count_in;
   logic       res_push;
   result_type res_item;

   logic        do_step;
   logic        collecting;
   logic [11:0] store_shift;
   logic [3:0]  held_sum;
   logic        byte_ready;
   logic        too_long;
   logic        pop_eff;

   assign rsp_empty = (res_count_ff == 2'd0);
   assign pop_eff   = rsp_pop && !rsp_empty;
   assign do_step   = cmd_valid && ((res_count_ff != 2'd2) || pop_eff);
   assign cmd_pop   = do_step;
   assign rsp_item  = res_q_ff[res_rd_ff];

   assign collecting  = (phase_ff == PH_COLLECT) && geom.ok;
   assign store_shift = {bit_store_ff[5:0], cmd.sextet};
   assign held_sum    = 4'(bits_held_ff) + 4'd6;
   assign byte_ready  = (held_sum >= 4'd8);
   assign too_long    = byte_ready && (emitted_ff >= geom.need);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (do_step) begin
         if (cmd.kind == CMD_TERM) begin
            phase_in = PH_COLLECT;
         end else if (phase_ff == PH_COLLECT) begin
            if (!geom.ok) begin
               phase_in = PH_ERROR;
            end else begin
               case (cmd.kind)
                  CMD_PAD:  phase_in = PH_STOPPED;
                  CMD_BAD:  phase_in = PH_ERROR;
                  CMD_DATA: phase_in = too_long ? PH_ERROR : PH_COLLECT;
                  default:  phase_in = phase_ff;
               endcase
            end
         end
      end
   end

   // Datapath and results
   always_comb begin
      bit_store_in = bit_store_ff;
      bits_held_in = bits_held_ff;
      emitted_in   = emitted_ff;
      error_in     = error_ff;
      res_push     = 1'b0;
      res_item     = '{data_byte: '0, kind: 1'b0, status: ST_OK, last: 1'b0};
      if (do_step) begin
         if (cmd.kind == CMD_TERM) begin
            res_push      = 1'b1;
            res_item.kind = 1'b1;
            res_item.last = 1'b1;
            if (!geom.ok) begin
               res_item.status = ST_GEOM;
            end else if (error_ff != ST_OK) begin
               res_item.status = error_ff;
            end else if (emitted_ff > geom.need) begin
               res_item.status = ST_LONG;
            end else if (emitted_ff < geom.need) begin
               res_item.status = ST_SHORT;
            end else begin
               res_item.status = ST_OK;
            end
            bit_store_in = '0;
            bits_held_in = '0;
            emitted_in   = '0;
            error_in     = ST_OK;
         end else if (phase_ff == PH_COLLECT && !geom.ok) begin
            if (error_ff == ST_OK) error_in = ST_GEOM;
         end else if (collecting) begin
            case (cmd.kind)
               CMD_BAD: begin
                  if (error_ff == ST_OK) error_in = ST_CHAR;
               end
               CMD_DATA: begin
                  bit_store_in = store_shift;
                  bits_held_in = byte_ready ? 3'(held_sum - 4'd8) : held_sum[2:0];
                  if (too_long) begin
                     if (error_ff == ST_OK) error_in = ST_LONG;
                  end else if (byte_ready) begin
                     res_push           = 1'b1;
                     res_item.data_byte = 8'(store_shift >> bits_held_in);
                     emitted_in         = emitted_ff + 1'b1;
                  end
               end
               default: begin
                  error_in = error_ff;
               end
            endcase
         end
      end
      res_count_in = res_count_ff + 2'(res_push) - 2'(pop_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_COLLECT;
         bit_store_ff <= '0;
         bits_held_ff <= '0;
         emitted_ff   <= '0;
         error_ff     <= ST_OK;
         res_wr_ff    <= 1'b0;
         res_rd_ff    <= 1'b0;
         res_count_ff <= '0;
      end else begin
         phase_ff     <= phase_in;
         bit_store_ff <= bit_store_in;
         bits_held_ff <= bits_held_in;
         emitted_ff   <= emitted_in;
         error_ff     <= error_in;
         res_wr_ff    <= res_wr_ff ^ res_push;
         res_rd_ff    <= res_rd_ff ^ pop_eff;
         res_count_ff <= res_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         res_q_ff[res_wr_ff] <= res_item;
      end
   end

endmodule

// File: hdl/base64_bitmap_payload_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_bitmap_payload_decoder_top
// Streaming base64 decoder for a bitmap payload with length checking.
// ----------------------------------------------------------------------------
// Feed one base64 character per request; code 0 ends the payload and always
// yields one status result (kind=1, last=1). Alphabet characters produce a
// decoded byte (kind=0) whenever eight bits are ready. The expected length is
// ceil(width/8)*height bytes from the two geometry registers; status codes
// are 0 ok, 1 bad geometry, 2 bad character, 3 too long, 4 too short. After
// an error or '=', no more bytes come out until the terminator. Keep the
// bytes only if the final status is ok. Throughput is one character per
// clock while the result queue has room or is popped: the front end classifies
// a character into a two-entry queue, and the back end updates the decode
// state per command into a two-entry result queue, which registers each
// result. Geometry writes are checked on the write itself (one multiply), so
// a request may follow a write in the next cycle; write only while idle.
// ----------------------------------------------------------------------------
module base64_bitmap_payload_decoder_top import b64d_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   // request side
   input  logic             req_push,
   output logic             req_full,
   input  logic [7:0]       req_char_code,
   // result side
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [7:0]       rsp_data_byte,
   output logic             rsp_kind,
   output logic [2:0]       rsp_status,
   output logic             rsp_last,
   // geometry registers
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CFG_W-1:0] csr_wdata
);

   geom_type   geom;
   cmd_type    cmd;
   logic       cmd_valid;
   logic       cmd_pop;
   result_type rsp_item;

   // width/height registers and the expected byte count
   b64d_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index_type'(csr_index)),
      .csr_wdata (csr_wdata),
      .geom      (geom)
   );

   // character intake and classification
   b64d_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_char_code (req_char_code),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop)
   );

   // decode state and result queue
   b64d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .geom      (geom),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   assign rsp_data_byte = rsp_item.data_byte;
   assign rsp_kind      = rsp_item.kind;
   assign rsp_status    = 3'(rsp_item.status);
   assign rsp_last      = rsp_item.last;

endmodule

// File: hdl/b64d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "base64_bitmap_payload_decoder_top_macros.svh"

module b64d_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_kind,
   input logic [2:0] rsp_status,
   input logic       rsp_last
);

   `B64D_ASSERT_NEXT(a_reset_clears, reset, rsp_empty && !req_full, "queues not empty after reset")
   `B64D_ASSERT_NOW(a_byte_fields, !reset && !rsp_empty && !rsp_kind, rsp_status == 3'd0 && !rsp_last, "byte result with status or last set")
   `B64D_ASSERT_NOW(a_status_fields, !reset && !rsp_empty && rsp_kind, rsp_last && rsp_data_byte == 8'd0 && rsp_status <= 3'd4, "malformed status result")
   `B64D_ASSERT_NEXT(a_hold, !reset && !rsp_empty && !rsp_pop, reset || (!rsp_empty && $stable(rsp_data_byte) && $stable(rsp_kind) && $stable(rsp_status)), "waiting result changed")

endmodule

bind base64_bitmap_payload_decoder_top b64d_checker u_b64d_checker (
   .clock         (clock),
   .reset         (reset),
   .req_full      (req_full),
   .rsp_empty     (rsp_empty),
   .rsp_pop       (rsp_pop),
   .rsp_data_byte (rsp_data_byte),
   .rsp_kind      (rsp_kind),
   .rsp_status    (rsp_status),
   .rsp_last      (rsp_last)
);
